// ===== src/qte_pkg.sv =====
// Shared types and constants for the quaternion to Euler angle converter.
package qte_pkg;

	localparam int ATAN_LEN   = 30;
	localparam int SQRT_STEPS = 31;
	localparam int CORDIC_W   = 36;

	localparam logic signed [33:0] Q30_ONE_W = 34'sd1073741824;
	localparam logic signed [32:0] Q30_ONE_N = 33'sd1073741824;
	localparam logic [60:0]        Q60_ONE   = 61'd1 << 60;

	localparam logic [31:0] TURN_HALF  = 32'h8000_0000;
	localparam logic [31:0] TURN_UP    = 32'h4000_0000;
	localparam logic [31:0] TURN_DOWN  = 32'hC000_0000;

	localparam logic [31:0] ATAN_TURNS [0:ATAN_LEN-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	typedef struct packed {
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} in_t;

	typedef struct packed {
		logic [15:0] angle_x;
		logic [15:0] angle_y;
		logic [15:0] angle_z;
		logic        gimbal_locked;
	} out_t;

	typedef struct packed {
		logic signed [31:0] m00;
		logic signed [31:0] m01;
		logic signed [31:0] m10;
		logic signed [31:0] m11;
		logic signed [31:0] m20;
		logic signed [31:0] m22;
		logic signed [31:0] s;
		logic               lock_p;
		logic               lock_n;
	} side_t;

	typedef struct packed {
		side_t       side;
		logic [60:0] rem;
	} mat_t;

	typedef struct packed {
		side_t       side;
		logic [30:0] root;
	} root_t;

endpackage

// ===== src/quaternion_to_euler_angles_unit.sv =====
// Top level of the quaternion to YXZ Euler angle converter.
//
//  channel  direction  handshake             payload
//  in       in         in_valid / in_stall   in_data   (quat_x, quat_y, quat_z, quat_w)
//  out      out        out_valid / out_stall out_data  (angle_x, angle_y, angle_z, locked)
//  cfg      in         cfg_valid / cfg_ready cfg_data  (gimbal_tolerance)
//
// One item enters per cycle while in_stall is low; the pipeline is five matrix
// stages, 31 root stages, one operand stage, the CORDIC stages and the output register.
// Reset clears all valid bits and sets the tolerance to 4.
// While a result is held by out_stall the whole pipeline holds and in_stall is raised.
module quaternion_to_euler_angles_unit #(
	parameter int CORDIC_STAGES = 16,
	parameter int ANGLE_BITS    = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  qte_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output qte_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [14:0]   cfg_data
);

	logic [14:0] tol_q;
	logic        en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tol_q <= 15'd4;
		else if (cfg_valid && cfg_ready)
			tol_q <= cfg_data;
	end

	assign cfg_ready = 1'b1;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;

	logic           mat_v;
	qte_pkg::mat_t  mat_d;
	logic           root_v;
	qte_pkg::root_t root_d;

	qte_matrix u_matrix (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (en),
		.gimbal_tolerance (tol_q),
		.in_valid         (in_valid),
		.in_data          (in_data),
		.out_valid        (mat_v),
		.out_data         (mat_d)
	);

	qte_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (mat_v),
		.in_data   (mat_d),
		.out_valid (root_v),
		.out_data  (root_d)
	);

	qte_cordic #(
		.CORDIC_STAGES (CORDIC_STAGES),
		.ANGLE_BITS    (ANGLE_BITS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (root_v),
		.in_data   (root_d),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

// ===== src/qte_matrix.sv =====
// Rotation matrix terms, gimbal lock test and sine-squared remainder, five stages.
module qte_matrix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [14:0]        gimbal_tolerance,
	input  logic               in_valid,
	input  qte_pkg::in_t       in_data,
	output logic               out_valid,
	output qte_pkg::mat_t      out_data
);

	function automatic logic signed [31:0] sat32(logic signed [33:0] v);
		if (v > 34'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (v < -34'sd2147483648)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

	// stage 1: products
	logic v_s1;
	logic signed [31:0] xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= in_data.quat_x * in_data.quat_x;
			yy_s1 <= in_data.quat_y * in_data.quat_y;
			zz_s1 <= in_data.quat_z * in_data.quat_z;
			xy_s1 <= in_data.quat_x * in_data.quat_y;
			xz_s1 <= in_data.quat_x * in_data.quat_z;
			yz_s1 <= in_data.quat_y * in_data.quat_z;
			wx_s1 <= in_data.quat_w * in_data.quat_x;
			wy_s1 <= in_data.quat_w * in_data.quat_y;
			wz_s1 <= in_data.quat_w * in_data.quat_z;
		end
	end

	// stage 2: saturated Q2.30 terms
	logic v_s2;
	logic signed [31:0] m00_s2, m01_s2, m10_s2, m11_s2, m20_s2, m21_s2, m22_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m00_s2 <= sat32(qte_pkg::Q30_ONE_W - (34'(yy_s1) <<< 1) - (34'(zz_s1) <<< 1));
			m11_s2 <= sat32(qte_pkg::Q30_ONE_W - (34'(xx_s1) <<< 1) - (34'(zz_s1) <<< 1));
			m22_s2 <= sat32(qte_pkg::Q30_ONE_W - (34'(xx_s1) <<< 1) - (34'(yy_s1) <<< 1));
			m01_s2 <= sat32((34'(xy_s1) <<< 1) + (34'(wz_s1) <<< 1));
			m10_s2 <= sat32((34'(xy_s1) <<< 1) - (34'(wz_s1) <<< 1));
			m20_s2 <= sat32((34'(xz_s1) <<< 1) + (34'(wy_s1) <<< 1));
			m21_s2 <= sat32((34'(yz_s1) <<< 1) - (34'(wx_s1) <<< 1));
		end
	end

	// stage 3: lock test, clamp sine
	logic signed [32:0] m21_w, tol_w, neg_w;
	logic signed [31:0] s_w;
	logic               lp_w, ln_w;
	logic signed [63:0] sq_w;

	always_comb begin
		m21_w = 33'(m21_s2);
		tol_w = $signed({3'b000, gimbal_tolerance, 15'b0});
		lp_w  = (m21_w >= qte_pkg::Q30_ONE_N - tol_w) && (m21_w <= qte_pkg::Q30_ONE_N + tol_w);
		ln_w  = !lp_w && (m21_w >= -qte_pkg::Q30_ONE_N - tol_w)
			&& (m21_w <= -qte_pkg::Q30_ONE_N + tol_w);
		neg_w = -m21_w;
		if (neg_w > qte_pkg::Q30_ONE_N)
			s_w = 32'(qte_pkg::Q30_ONE_N);
		else if (neg_w < -qte_pkg::Q30_ONE_N)
			s_w = 32'(-qte_pkg::Q30_ONE_N);
		else
			s_w = neg_w[31:0];
	end

	logic v_s3;
	qte_pkg::side_t side_s3;
	logic [60:0] sq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	assign sq_w = side_s3.s * side_s3.s;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.m00    <= m00_s2;
			side_s3.m01    <= m01_s2;
			side_s3.m10    <= m10_s2;
			side_s3.m11    <= m11_s2;
			side_s3.m20    <= m20_s2;
			side_s3.m22    <= m22_s2;
			side_s3.s      <= s_w;
			side_s3.lock_p <= lp_w;
			side_s3.lock_n <= ln_w;
		end
	end

	// the square lands one stage after the clamped sine
	logic v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	logic v_s5;
	qte_pkg::side_t side_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			sq_s3   <= sq_w[60:0];
		end
	end

	// stage 5: remainder under the root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.side <= side_s4;
			out_data.rem  <= qte_pkg::Q60_ONE - sq_s3;
		end
	end

	assign out_valid = v_s5;

endmodule

// ===== src/qte_isqrt.sv =====
// Pipelined floor square root, one result bit per stage.
module qte_isqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  qte_pkg::mat_t      in_data,
	output logic               out_valid,
	output qte_pkg::root_t     out_data
);

	localparam int N = qte_pkg::SQRT_STEPS;

	logic           v_s    [0:N];
	logic [61:0]    rem_s  [0:N];
	logic [61:0]    res_s  [0:N];
	qte_pkg::side_t side_s [0:N];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = {1'b0, in_data.rem};
	assign res_s[0]  = '0;
	assign side_s[0] = in_data.side;

	for (genvar j = 0; j < N; j++) begin : g_step
		localparam logic [61:0] BIT = 62'd1 << (2 * (N - 1 - j));
		logic [61:0] t;
		logic        ge;

		assign t  = res_s[j] + BIT;
		assign ge = rem_s[j] >= t;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[j+1] <= 1'b0;
			else if (en)
				v_s[j+1] <= v_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? rem_s[j] - t : rem_s[j];
				res_s[j+1]  <= ge ? (res_s[j] >> 1) + BIT : res_s[j] >> 1;
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_valid     = v_s[N];
	assign out_data.side = side_s[N];
	assign out_data.root = res_s[N][30:0];

endmodule

// ===== src/qte_cordic.sv =====
// Three vectoring CORDIC lanes, lock override and angle rounding.
module qte_cordic #(
	parameter int CORDIC_STAGES = 16,
	parameter int ANGLE_BITS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  qte_pkg::root_t     in_data,
	output logic               out_valid,
	output qte_pkg::out_t      out_data
);

	localparam int N = CORDIC_STAGES;
	localparam int W = qte_pkg::CORDIC_W;

	typedef struct packed {
		logic signed [W-1:0] x;
		logic signed [W-1:0] y;
		logic [31:0]         ang;
		logic                zero;
	} lane_t;

	function automatic lane_t pre_rotate(logic signed [W-1:0] y, logic signed [W-1:0] x);
		lane_t l;
		l.zero = (x == '0) && (y == '0);
		if (x < 0) begin
			l.x   = -x;
			l.y   = -y;
			l.ang = qte_pkg::TURN_HALF;
		end else begin
			l.x   = x;
			l.y   = y;
			l.ang = '0;
		end
		return l;
	endfunction

	function automatic lane_t rotate(lane_t l, int i);
		lane_t r;
		r = l;
		if (l.y > 0) begin
			r.x   = l.x + (l.y >>> i);
			r.y   = l.y - (l.x >>> i);
			r.ang = l.ang + qte_pkg::ATAN_TURNS[i];
		end else begin
			r.x   = l.x - (l.y >>> i);
			r.y   = l.y + (l.x >>> i);
			r.ang = l.ang - qte_pkg::ATAN_TURNS[i];
		end
		return r;
	endfunction

	function automatic logic [15:0] to_out(logic [31:0] a);
		logic [31:0]           r;
		logic [ANGLE_BITS-1:0] f;
		r = a + (32'd1 << (31 - ANGLE_BITS));
		f = r[31 -: ANGLE_BITS];
		return 16'(f);
	endfunction

	logic  v_s     [0:N];
	lane_t a_s     [0:N];
	lane_t b_s     [0:N];
	lane_t c_s     [0:N];
	logic  lp_s    [0:N];
	logic  ln_s    [0:N];

	// stage 0: pick operands, turn negative-x operands by half a turn
	logic signed [W-1:0] cy_w, cx_w;

	always_comb begin
		if (in_data.side.lock_p || in_data.side.lock_n) begin
			cy_w = -W'(in_data.side.m10);
			cx_w = W'(in_data.side.m00);
		end else begin
			cy_w = W'(in_data.side.m01);
			cx_w = W'(in_data.side.m11);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else if (en)
			v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s[0]  <= pre_rotate(W'(in_data.side.s), $signed({5'b0, in_data.root}));
			b_s[0]  <= pre_rotate(W'(in_data.side.m20), W'(in_data.side.m22));
			c_s[0]  <= pre_rotate(cy_w, cx_w);
			lp_s[0] <= in_data.side.lock_p;
			ln_s[0] <= in_data.side.lock_n;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (en)
				v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				a_s[i+1]  <= rotate(a_s[i], i);
				b_s[i+1]  <= rotate(b_s[i], i);
				c_s[i+1]  <= rotate(c_s[i], i);
				lp_s[i+1] <= lp_s[i];
				ln_s[i+1] <= ln_s[i];
			end
		end
	end

	// output stage: override on lock, round to the output angle
	logic [31:0] ax_w, ay_w, az_w;
	logic        lock_w;

	always_comb begin
		lock_w = lp_s[N] || ln_s[N];
		az_w   = c_s[N].zero ? '0 : c_s[N].ang;
		if (lp_s[N])
			ax_w = qte_pkg::TURN_DOWN;
		else if (ln_s[N])
			ax_w = qte_pkg::TURN_UP;
		else
			ax_w = a_s[N].zero ? '0 : a_s[N].ang;
		ay_w = (lock_w || b_s[N].zero) ? '0 : b_s[N].ang;
	end

	logic v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (en)
			v_q <= v_s[N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.angle_x       <= to_out(ax_w);
			out_data.angle_y       <= to_out(ay_w);
			out_data.angle_z       <= to_out(az_w);
			out_data.gimbal_locked <= lock_w;
		end
	end

	assign out_valid = v_q;

`ifndef SYNTHESIS
	a_lock_y_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.gimbal_locked |-> out_data.angle_y == '0)
		else $error("locked item with nonzero y angle");

	a_one_lock_side: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[0] |-> !(lp_s[0] && ln_s[0]))
		else $error("both lock sides set");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !en |=> out_valid && $stable(out_data))
		else $error("result changed while held");
`endif

endmodule

// ===== tb/qte_checker.sv =====
// Checker for the quaternion to Euler angle converter: predicts each result and compares it.
module qte_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_stall,
	input  qte_pkg::in_t  in_data,
	input  logic          out_valid,
	input  logic          out_stall,
	input  qte_pkg::out_t out_data,
	input  logic          cfg_valid,
	input  logic          cfg_ready,
	input  logic [14:0]   cfg_data,
	output int            errors,
	output int            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STAGES = 16;
	localparam longint ONE_Q30 = 64'sd1 << 30;

	logic [14:0]   tolerance;
	qte_pkg::out_t angles_due[$];

	function automatic longint clamp_q230(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint floor_root(longint unsigned v);
		longint unsigned res, bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v)
			bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v = v - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return longint'(res);
	endfunction

	// vectoring CORDIC, 32-bit binary angle
	function automatic logic [31:0] turn_angle(longint yv, longint xv);
		logic [31:0] acc;
		longint dx, dy;
		acc = '0;
		if (xv == 0 && yv == 0)
			return '0;
		if (xv < 0) begin
			xv = -xv;
			yv = -yv;
			acc = qte_pkg::TURN_HALF;
		end
		for (int i = 0; i < STAGES; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (yv > 0) begin
				xv = xv + dx;
				yv = yv - dy;
				acc = acc + qte_pkg::ATAN_TURNS[i];
			end else begin
				xv = xv - dx;
				yv = yv + dy;
				acc = acc - qte_pkg::ATAN_TURNS[i];
			end
		end
		return acc;
	endfunction

	function automatic logic [15:0] round_angle(logic [31:0] a);
		logic [31:0] r;
		r = a + 32'h0000_8000;
		return r[31:16];
	endfunction

	function automatic qte_pkg::out_t euler_of(qte_pkg::in_t q, logic [14:0] tol_q15);
		longint qx, qy, qz, qw, m00, m01, m10, m11, m20, m21, m22, tol, s, c;
		logic [31:0] ax, ay, az;
		qte_pkg::out_t r;
		qx = q.quat_x;
		qy = q.quat_y;
		qz = q.quat_z;
		qw = q.quat_w;
		m00 = clamp_q230(ONE_Q30 - 2*qy*qy - 2*qz*qz);
		m01 = clamp_q230(2*qx*qy + 2*qw*qz);
		m10 = clamp_q230(2*qx*qy - 2*qw*qz);
		m11 = clamp_q230(ONE_Q30 - 2*qx*qx - 2*qz*qz);
		m20 = clamp_q230(2*qx*qz + 2*qw*qy);
		m21 = clamp_q230(2*qy*qz - 2*qw*qx);
		m22 = clamp_q230(ONE_Q30 - 2*qx*qx - 2*qy*qy);
		tol = longint'(tol_q15) << 15;
		r.gimbal_locked = 1'b1;
		if (m21 >= ONE_Q30 - tol && m21 <= ONE_Q30 + tol) begin
			ax = qte_pkg::TURN_DOWN;
			ay = '0;
			az = turn_angle(-m10, m00);
		end else if (m21 >= -ONE_Q30 - tol && m21 <= -ONE_Q30 + tol) begin
			ax = qte_pkg::TURN_UP;
			ay = '0;
			az = turn_angle(-m10, m00);
		end else begin
			s = -m21;
			if (s > ONE_Q30)
				s = ONE_Q30;
			if (s < -ONE_Q30)
				s = -ONE_Q30;
			c = floor_root(longint'(64'd1 << 60) - s*s);
			ax = turn_angle(s, c);
			ay = turn_angle(m20, m22);
			az = turn_angle(m01, m11);
			r.gimbal_locked = 1'b0;
		end
		r.angle_x = round_angle(ax);
		r.angle_y = round_angle(ay);
		r.angle_z = round_angle(az);
		return r;
	endfunction

	assign pending = angles_due.size();

	always @(posedge clk or negedge arst_n) begin
		qte_pkg::out_t want;
		if (!arst_n) begin
			tolerance <= 15'd4;
			errors <= 0;
			angles_due.delete();
		end else begin
			if (in_valid && !in_stall)
				angles_due.push_back(euler_of(in_data, tolerance));
			if (cfg_valid && cfg_ready)
				tolerance <= cfg_data;
			if (out_valid && !out_stall) begin
				if (angles_due.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					errors <= errors + 1;
				end else begin
					want = angles_due.pop_front();
					if (want.angle_x !== out_data.angle_x
							|| want.angle_y !== out_data.angle_y
							|| want.angle_z !== out_data.angle_z
							|| want.gimbal_locked !== out_data.gimbal_locked) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, out_data);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top: drives quaternions and tolerance writes, gives the verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 16 + 38;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	qte_pkg::in_t  in_data = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	qte_pkg::out_t out_data;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [14:0]   cfg_data = '0;
	int            errors, pending;
	bit            calm = 1'b0;
	bit            hold_off = 1'b0;

	quaternion_to_euler_angles_unit dut (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
		.out_data, .cfg_valid, .cfg_ready, .cfg_data
	);

	qte_checker chk (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
		.out_data, .cfg_valid, .cfg_ready, .cfg_data, .errors, .pending
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic qte_pkg::in_t quat(int x, int y, int z, int w);
		qte_pkg::in_t q;
		q.quat_x = 16'(x);
		q.quat_y = 16'(y);
		q.quat_z = 16'(z);
		q.quat_w = 16'(w);
		return q;
	endfunction

	function automatic int to_q15(real v);
		int r;
		r = $rtoi(v * 32768.0);
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r;
	endfunction

	function automatic real rnd_unit();
		return ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
	endfunction

	// raw random bits, a unit quaternion, or one placed near gimbal lock with a small jitter
	function automatic qte_pkg::in_t pick_quat();
		real a, b, c, d, n, th;
		int j, sgn;
		case ($urandom_range(0, 9)) inside
			[0:1]: return qte_pkg::in_t'({$urandom, $urandom});
			[2:4]: begin
				th = rnd_unit() * 3.14159265;
				sgn = $urandom_range(0, 1) ? 1 : -1;
				j = $urandom_range(0, 64) - 32;
				a = 0.70710678 * $cos(th);
				b = 0.70710678 * $sin(th);
				return quat(to_q15(a) + j, to_q15(b), -sgn * to_q15(b), sgn * to_q15(a));
			end
			default: begin
				a = rnd_unit();
				b = rnd_unit();
				c = rnd_unit();
				d = rnd_unit();
				n = $sqrt(a*a + b*b + c*c + d*d);
				if (n < 1.0e-3)
					return quat(0, 0, 0, 32767);
				return quat(to_q15(a/n), to_q15(b/n), to_q15(c/n), to_q15(d/n));
			end
		endcase
	endfunction

	task automatic send(qte_pkg::in_t q);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= q;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_tolerance(logic [14:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (LATENCY + 4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// receiver stalls
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end else if (calm || $urandom_range(0, 3) != 0) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	initial begin
		#2ms;
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [14:0] tols [5];
		tols = '{15'd0, 15'd32767, 15'd200, 15'd0, 15'd1000};
		tols[3] = 15'($urandom_range(1, 32766));
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// extremes and the two lock sides at the reset tolerance
		send(quat(0, 0, 0, 32767));
		send(quat(0, 0, 0, -32768));
		send(quat(-32768, -32768, -32768, -32768));
		send(quat(32767, 32767, 32767, 32767));
		send(quat(32767, -32768, 32767, -32768));
		send(quat(0, 0, 0, 0));
		send(quat(23170, 0, 0, 23170));
		send(quat(23170, 0, 0, -23170));
		send(quat(23170, 23170, -23170, 23170));
		send(quat(-23170, 23170, 23170, 23170));
		send(quat(32767, 0, 0, 0));
		send(quat(0, 32767, 0, 0));
		send(quat(0, 0, 32767, 0));
		send(quat(0, 0, 23170, 23170));
		send(quat(16384, 16384, 16384, 16384));
		send(quat(-1, 1, -1, 1));
		for (int p = 0; p < 5; p++) begin
			write_tolerance(tols[p]);
			for (int i = 0; i < 170; i++) begin
				if (p == 1 && i == 50)
					hold_off = 1'b1;
				if (p == 4 && i == 80)
					calm = 1'b1;
				send(pick_quat());
			end
		end
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
